[hdl/pbh_pkg.sv]
// shared types, constants and tables of the patchy bond histogram
`timescale 1ns / 1ps
package pbh_pkg;

	localparam int MAX_PARTICLES = 1024;
	localparam int PTR_W         = $clog2(MAX_PARTICLES);
	localparam int CNT_W         = PTR_W + 1;
	localparam int PATCH_DEPTH   = 3 * MAX_PARTICLES;
	localparam int PADDR_W       = $clog2(PATCH_DEPTH);
	localparam int BIN_SLOTS     = 128;
	localparam int BIN_W         = 7;
	localparam int BIN_HEIGHT    = 2;

	localparam logic [1:0] CFG_HEIGHT_LIMIT  = 2'd0;
	localparam logic [1:0] CFG_CONTACT_RANGE = 2'd1;
	localparam logic [1:0] CFG_PATCH_RANGE   = 2'd2;

	localparam logic [1:0] ERR_OK     = 2'd0;
	localparam logic [1:0] ERR_HEIGHT = 2'd1;
	localparam logic [1:0] ERR_FULL   = 2'd2;

	localparam logic CMD_ADD  = 1'b0;
	localparam logic CMD_READ = 1'b1;

	typedef struct packed {
		logic signed [24:0] cx;
		logic [23:0]        cz;
		logic [1:0]         cnt;
		logic [BIN_W-1:0]   bin;
	} centre_entry_t;

	typedef struct packed {
		logic signed [25:0] x;
		logic signed [25:0] z;
	} patch_entry_t;

	typedef struct packed {
		logic              centre_re;
		logic              centre_we;
		logic [PTR_W-1:0]  centre_addr;
		logic              patch_re;
		logic              patch_we;
		logic [PADDR_W-1:0] patch_addr;
	} store_req_t;

	typedef struct packed {
		logic [39:0] bond;
		logic [39:0] patch;
		logic [31:0] particle;
		logic [31:0] three;
	} sums_t;

	typedef struct packed {
		logic             re;
		logic [BIN_W-1:0] raddr;
		logic             we;
		logic [BIN_W-1:0] waddr;
	} sums_req_t;

	// 32768*sin(k*pi/32)
	function automatic logic [15:0] sine_tab(input logic [4:0] k);
		logic [15:0] v;
		unique case (k)
			5'd0:  v = 16'd0;
			5'd1:  v = 16'd3212;
			5'd2:  v = 16'd6393;
			5'd3:  v = 16'd9512;
			5'd4:  v = 16'd12540;
			5'd5:  v = 16'd15447;
			5'd6:  v = 16'd18205;
			5'd7:  v = 16'd20788;
			5'd8:  v = 16'd23170;
			5'd9:  v = 16'd25330;
			5'd10: v = 16'd27246;
			5'd11: v = 16'd28899;
			5'd12: v = 16'd30274;
			5'd13: v = 16'd31357;
			5'd14: v = 16'd32138;
			5'd15: v = 16'd32610;
			5'd16: v = 16'd32768;
			default: v = 16'd0;
		endcase
		return v;
	endfunction

	function automatic logic [15:0] patch_offset(input logic three, input logic [1:0] idx);
		logic [15:0] v;
		v = 16'd0;
		if (three) begin
			if (idx == 2'd1) v = 16'd21845;
			else if (idx == 2'd2) v = 16'd43691;
		end else if (idx[0]) begin
			v = 16'd32768;
		end
		return v;
	endfunction

	function automatic logic [39:0] sat40(input logic [39:0] a, input logic [39:0] b);
		logic [40:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[40] ? {40{1'b1}} : s[39:0];
	endfunction

	function automatic logic [31:0] sat32(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? {32{1'b1}} : s[31:0];
	endfunction

endpackage

[hdl/patchy_bond_histogram.sv]
// top level: sequencer around one shared multiplier, store and bin sums
//
// channel   handshake               payload
// in        in_valid / in_stall     command start_frame species pos_x pos_z angle bin_select
// out       out_valid / out_stall   bin_index bonds_found bin_*_total error_code
// cfg       cfg_write               cfg_index cfg_data
//
// read: fetches the sums of the selected bin. add: places the patches of the new particle,
// then tests each stored particle for contact and, in contact, its patch pairs for bonds.
// every squared distance takes two passes through the one multiplier.
// bin sums read as zero after reset through valid flags, no clearing pass.
// in_stall is high while an item is worked; a result waits in the output register.
`timescale 1ns / 1ps
module patchy_bond_histogram (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               command,
	input  logic               start_frame,
	input  logic               species,
	input  logic signed [24:0] pos_x,
	input  logic [23:0]        pos_z,
	input  logic [15:0]        angle,
	input  logic [6:0]         bin_select,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [6:0]         bin_index,
	output logic [10:0]        bonds_found,
	output logic [39:0]        bin_bond_total,
	output logic [39:0]        bin_patch_total,
	output logic [31:0]        bin_particle_total,
	output logic [31:0]        bin_three_patch_total,
	output logic [1:0]         error_code,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [17:0]        cfg_data
);
	import pbh_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE, ST_DECODE, ST_CR, ST_PR, ST_PR2, ST_SIN_M, ST_SIN_A,
		ST_SCAN, ST_C_WAIT, ST_C_DZ, ST_C_CMP, ST_P_WAIT, ST_P_DZ, ST_P_CMP,
		ST_B_WR, ST_F_WR, ST_RD_WAIT, ST_OUT
	} state_t;

	state_t state_q;

	logic [8:0]  height_limit_q;
	logic [17:0] contact_range_q;
	logic [17:0] patch_range_q;

	logic               cmd_q, start_q, species_q;
	logic signed [24:0] cx_q;
	logic [23:0]        cz_q;
	logic [15:0]        angle_q;
	logic [BIN_W-1:0]   sel_q, bin_q, oth_bin_q;
	logic [1:0]         oth_cnt_q;

	logic [CNT_W-1:0] count_q, cur_q, j_q, bonds_q;
	logic [1:0]       pi_q, pj_q;
	logic             sc_q;

	logic signed [25:0] npx_q [3];
	logic signed [25:0] npz_q [3];

	logic signed [53:0] mul_q;
	logic [52:0]        dxsq_q;
	logic [35:0]        cr_q, pr_q;
	logic [15:0]        sbase_q;
	logic               ssat_q, sneg_q;

	logic [BIN_W-1:0] res_bin_q;
	logic [10:0]      res_bonds_q;
	sums_t            res_sums_q;
	logic [1:0]       res_err_q;

	logic        out_valid_q;
	logic [6:0]  out_bin_q;
	logic [10:0] out_bonds_q;
	sums_t       out_sums_q;
	logic [1:0]  out_err_q;

	store_req_t    st_req;
	centre_entry_t centre_wdata, centre_rdata;
	patch_entry_t  patch_wdata, patch_rdata;
	sums_req_t     sm_req;
	sums_t         sums_wdata, sums_rdata;

	logic signed [26:0] mul_a, mul_b;
	logic signed [53:0] mul_p;
	logic signed [26:0] cdx, cdz, pdx, pdz;
	logic [53:0]        sq_sum;
	logic [15:0]        phase;
	logic [14:0]        uu;
	logic [4:0]         ti;
	logic [15:0]        tb, tn;
	logic [11:0]        tdiff;
	logic [11:0]        rnd;
	logic [15:0]        mag;
	logic signed [25:0] sval, coord;
	logic [1:0]         npatch;
	logic [7:0]         bin_full;
	logic               height_bad;
	logic [CNT_W-1:0]   cur_eff;
	logic [1:0]         pj_nxt;
	logic               out_free, in_accept;

	assign in_accept = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign npatch    = species_q ? 2'd3 : 2'd2;

	assign bin_full   = 8'(cz_q[23:16] / BIN_HEIGHT);
	assign height_bad = ({1'b0, cz_q[23:16]} >= height_limit_q) ||
		(bin_full >= 8'(BIN_SLOTS));
	assign cur_eff    = start_q ? '0 : count_q;

	// phase decode for the interpolated sine
	always_comb begin
		phase = angle_q + patch_offset(species_q, pi_q) + (sc_q ? 16'd0 : 16'd16384);
		uu    = phase[14] ? (15'd16384 - {1'b0, phase[13:0]}) : {1'b0, phase[13:0]};
		ti    = uu[14:10];
		tb    = sine_tab(ti);
		tn    = sine_tab(ti + 5'd1);
		tdiff = 12'(tn - tb);
		rnd   = 12'(({1'b0, mul_q[21:0]} + 23'd512) >> 10);
		mag   = ssat_q ? 16'd32768 : (sbase_q + 16'(rnd));
		sval  = sneg_q ? -$signed({10'd0, mag}) : $signed({10'd0, mag});
		coord = (sc_q ? $signed({2'b00, cz_q}) : $signed({cx_q[24], cx_q})) + sval;
	end

	assign cdx = $signed({{2{cx_q[24]}}, cx_q}) -
		$signed({{2{centre_rdata.cx[24]}}, centre_rdata.cx});
	assign cdz = $signed({3'b000, cz_q}) - $signed({3'b000, centre_rdata.cz});
	assign pdx = $signed({npx_q[pi_q][25], npx_q[pi_q]}) -
		$signed({patch_rdata.x[25], patch_rdata.x});
	assign pdz = $signed({npz_q[pi_q][25], npz_q[pi_q]}) -
		$signed({patch_rdata.z[25], patch_rdata.z});
	assign sq_sum = {1'b0, dxsq_q} + {1'b0, mul_q[52:0]};

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_CR: begin
				mul_a = $signed({9'd0, contact_range_q});
				mul_b = mul_a;
			end
			ST_PR: begin
				mul_a = $signed({9'd0, patch_range_q});
				mul_b = mul_a;
			end
			ST_SIN_M: begin
				mul_a = $signed({15'd0, tdiff});
				mul_b = $signed({17'd0, uu[9:0]});
			end
			ST_C_WAIT: begin
				mul_a = cdx;
				mul_b = cdx;
			end
			ST_C_DZ: begin
				mul_a = cdz;
				mul_b = cdz;
			end
			ST_P_WAIT: begin
				mul_a = pdx;
				mul_b = pdx;
			end
			ST_P_DZ: begin
				mul_a = pdz;
				mul_b = pdz;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// memory requests
	always_comb begin
		pj_nxt = (state_q == ST_P_CMP) ? (pj_q + 2'd1) : 2'd0;
		st_req.centre_re   = (state_q == ST_SCAN) && (j_q != cur_q);
		st_req.centre_we   = (state_q == ST_CR);
		st_req.centre_addr = (state_q == ST_CR) ? cur_q[PTR_W-1:0] : j_q[PTR_W-1:0];
		st_req.patch_we    = (state_q == ST_SIN_A) && sc_q;
		st_req.patch_re    = (state_q == ST_C_CMP) ||
			((state_q == ST_P_CMP) && (pi_q == npatch - 2'd1));
		if (state_q == ST_SIN_A)
			st_req.patch_addr = PADDR_W'({cur_q[PTR_W-1:0], 1'b0}) +
				PADDR_W'(cur_q[PTR_W-1:0]) + PADDR_W'(pi_q);
		else
			st_req.patch_addr = PADDR_W'({j_q[PTR_W-1:0], 1'b0}) +
				PADDR_W'(j_q[PTR_W-1:0]) + PADDR_W'(pj_nxt);

		centre_wdata.cx  = cx_q;
		centre_wdata.cz  = cz_q;
		centre_wdata.cnt = npatch;
		centre_wdata.bin = bin_q;
		patch_wdata.x    = npx_q[pi_q];
		patch_wdata.z    = coord;

		sm_req.re    = ((state_q == ST_DECODE) && (cmd_q == CMD_READ)) ||
			(state_q == ST_P_CMP) || ((state_q == ST_SCAN) && (j_q == cur_q));
		sm_req.raddr = (state_q == ST_DECODE) ? sel_q :
			((state_q == ST_P_CMP) ? oth_bin_q : bin_q);
		sm_req.we    = (state_q == ST_B_WR) || (state_q == ST_F_WR);
		sm_req.waddr = (state_q == ST_B_WR) ? oth_bin_q : bin_q;

		if (state_q == ST_B_WR) begin
			sums_wdata      = sums_rdata;
			sums_wdata.bond = sat40(sums_rdata.bond, 40'd1);
		end else begin
			sums_wdata.bond     = sat40(sums_rdata.bond, 40'(bonds_q));
			sums_wdata.patch    = sat40(sums_rdata.patch, 40'(npatch));
			sums_wdata.particle = sat32(sums_rdata.particle, 32'd1);
			sums_wdata.three    = sat32(sums_rdata.three, 32'(species_q));
		end
	end

	pbh_store u_store (
		.clk          (clk),
		.req          (st_req),
		.centre_wdata (centre_wdata),
		.patch_wdata  (patch_wdata),
		.centre_rdata (centre_rdata),
		.patch_rdata  (patch_rdata)
	);

	pbh_sums u_sums (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sm_req),
		.wdata  (sums_wdata),
		.rdata  (sums_rdata)
	);

	// datapath registers
	always_ff @(posedge clk) begin
		mul_q <= mul_p;
		if (in_accept) begin
			cmd_q     <= command;
			start_q   <= start_frame;
			species_q <= species;
			cx_q      <= pos_x;
			cz_q      <= pos_z;
			angle_q   <= angle;
			sel_q     <= bin_select;
		end
		unique case (state_q)
			ST_DECODE: begin
				bin_q <= bin_full[BIN_W-1:0];
				cur_q <= cur_eff;
			end
			ST_PR:  cr_q <= mul_q[35:0];
			ST_PR2: pr_q <= mul_q[35:0];
			ST_SIN_M: begin
				sbase_q <= tb;
				ssat_q  <= uu[14];
				sneg_q  <= phase[15];
			end
			ST_SIN_A: begin
				if (sc_q) npz_q[pi_q] <= coord;
				else      npx_q[pi_q] <= coord;
			end
			ST_C_WAIT: begin
				oth_cnt_q <= centre_rdata.cnt;
				oth_bin_q <= centre_rdata.bin;
			end
			ST_C_DZ: dxsq_q <= mul_q[52:0];
			ST_P_DZ: dxsq_q <= mul_q[52:0];
			default: ;
		endcase
	end

	// sequencer, counters and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			height_limit_q  <= 9'd200;
			contact_range_q <= 18'd73377;
			patch_range_q   <= 18'd7842;
			count_q         <= '0;
			j_q             <= '0;
			bonds_q         <= '0;
			pi_q            <= '0;
			pj_q            <= '0;
			sc_q            <= 1'b0;
			out_valid_q     <= 1'b0;
			res_bin_q       <= '0;
			res_bonds_q     <= '0;
			res_sums_q      <= '0;
			res_err_q       <= ERR_OK;
			out_bin_q       <= '0;
			out_bonds_q     <= '0;
			out_sums_q      <= '0;
			out_err_q       <= ERR_OK;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					CFG_HEIGHT_LIMIT:  height_limit_q  <= cfg_data[8:0];
					CFG_CONTACT_RANGE: contact_range_q <= cfg_data;
					CFG_PATCH_RANGE:   patch_range_q   <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) state_q <= ST_DECODE;
				end
				ST_DECODE: begin
					res_bin_q   <= '0;
					res_bonds_q <= '0;
					res_sums_q  <= '0;
					res_err_q   <= ERR_OK;
					if (cmd_q == CMD_READ) begin
						state_q <= ST_RD_WAIT;
					end else begin
						count_q <= cur_eff;
						if (height_bad) begin
							res_err_q <= ERR_HEIGHT;
							state_q   <= ST_OUT;
						end else if (cur_eff >= CNT_W'(MAX_PARTICLES)) begin
							res_err_q <= ERR_FULL;
							state_q   <= ST_OUT;
						end else begin
							state_q <= ST_CR;
						end
					end
				end
				ST_CR: state_q <= ST_PR;
				ST_PR: state_q <= ST_PR2;
				ST_PR2: begin
					pi_q    <= '0;
					sc_q    <= 1'b0;
					state_q <= ST_SIN_M;
				end
				ST_SIN_M: state_q <= ST_SIN_A;
				ST_SIN_A: begin
					if (!sc_q) begin
						sc_q    <= 1'b1;
						state_q <= ST_SIN_M;
					end else if (pi_q == npatch - 2'd1) begin
						sc_q    <= 1'b0;
						j_q     <= '0;
						bonds_q <= '0;
						state_q <= ST_SCAN;
					end else begin
						sc_q    <= 1'b0;
						pi_q    <= pi_q + 2'd1;
						state_q <= ST_SIN_M;
					end
				end
				ST_SCAN: begin
					if (j_q == cur_q) state_q <= ST_F_WR;
					else              state_q <= ST_C_WAIT;
				end
				ST_C_WAIT: state_q <= ST_C_DZ;
				ST_C_DZ:   state_q <= ST_C_CMP;
				ST_C_CMP: begin
					if (sq_sum > {18'd0, cr_q}) begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_SCAN;
					end else begin
						pi_q    <= '0;
						pj_q    <= '0;
						state_q <= ST_P_WAIT;
					end
				end
				ST_P_WAIT: state_q <= ST_P_DZ;
				ST_P_DZ:   state_q <= ST_P_CMP;
				ST_P_CMP: begin
					if (sq_sum <= {18'd0, pr_q}) begin
						state_q <= ST_B_WR;
					end else if (pi_q != npatch - 2'd1) begin
						pi_q    <= pi_q + 2'd1;
						state_q <= ST_P_WAIT;
					end else if (pj_q != oth_cnt_q - 2'd1) begin
						pi_q    <= '0;
						pj_q    <= pj_q + 2'd1;
						state_q <= ST_P_WAIT;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_SCAN;
					end
				end
				ST_B_WR: begin
					bonds_q <= bonds_q + 1'b1;
					j_q     <= j_q + 1'b1;
					state_q <= ST_SCAN;
				end
				ST_F_WR: begin
					count_q     <= cur_q + 1'b1;
					res_bin_q   <= bin_q;
					res_bonds_q <= bonds_q;
					res_sums_q  <= sums_wdata;
					res_err_q   <= ERR_OK;
					state_q     <= ST_OUT;
				end
				ST_RD_WAIT: begin
					res_bin_q  <= sel_q;
					res_sums_q <= sums_rdata;
					state_q    <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_bin_q   <= res_bin_q;
						out_bonds_q <= res_bonds_q;
						out_sums_q  <= res_sums_q;
						out_err_q   <= res_err_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid             = out_valid_q;
	assign bin_index             = out_bin_q;
	assign bonds_found           = out_bonds_q;
	assign bin_bond_total        = out_sums_q.bond;
	assign bin_patch_total       = out_sums_q.patch;
	assign bin_particle_total    = out_sums_q.particle;
	assign bin_three_patch_total = out_sums_q.three;
	assign error_code            = out_err_q;

endmodule

[hdl/pbh_store.sv]
// particle store: centre and patch memories of the current frame
`timescale 1ns / 1ps
module pbh_store (
	input  logic                    clk,
	input  pbh_pkg::store_req_t     req,
	input  pbh_pkg::centre_entry_t  centre_wdata,
	input  pbh_pkg::patch_entry_t   patch_wdata,
	output pbh_pkg::centre_entry_t  centre_rdata,
	output pbh_pkg::patch_entry_t   patch_rdata
);
	import pbh_pkg::*;

	centre_entry_t centre_mem [MAX_PARTICLES];
	patch_entry_t  patch_mem  [PATCH_DEPTH];
	centre_entry_t centre_q;
	patch_entry_t  patch_q;

	always_ff @(posedge clk) begin
		if (req.centre_we) centre_mem[req.centre_addr] <= centre_wdata;
		if (req.centre_re) centre_q <= centre_mem[req.centre_addr];
	end

	always_ff @(posedge clk) begin
		if (req.patch_we) patch_mem[req.patch_addr] <= patch_wdata;
		if (req.patch_re) patch_q <= patch_mem[req.patch_addr];
	end

	assign centre_rdata = centre_q;
	assign patch_rdata  = patch_q;

endmodule

[hdl/pbh_sums.sv]
// per-bin sum memory with valid flags for reset to zero
`timescale 1ns / 1ps
module pbh_sums (
	input  logic               clk,
	input  logic               arst_n,
	input  pbh_pkg::sums_req_t req,
	input  pbh_pkg::sums_t     wdata,
	output pbh_pkg::sums_t     rdata
);
	import pbh_pkg::*;

	sums_t                mem [BIN_SLOTS];
	sums_t                rd_q;
	logic [BIN_SLOTS-1:0] valid_q;
	logic                 rv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rv_q    <= 1'b0;
		end else begin
			if (req.we) valid_q[req.waddr] <= 1'b1;
			if (req.re) rv_q <= valid_q[req.raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (req.we) mem[req.waddr] <= wdata;
		if (req.re) rd_q <= mem[req.raddr];
	end

	assign rdata = rv_q ? rd_q : '0;

endmodule
